/* sv/sqlts_pkg.sv */
// sqlts_pkg: token codes, result item type and keyword table for the sql token scanner
// used by sqlts_core, sqlts_outq and sql_token_scanner; no dependencies
package sqlts_pkg;

  localparam int MAX_TEXT_BYTES_DEF  = 65536;
  localparam int LONGEST_KEYWORD_DEF = 11;
  localparam int KW_COUNT            = 41;
  localparam int KW_CHARS            = 11;
  localparam int KW_CNT_W            = 5;

  localparam logic [5:0] K_EOF    = 6'd0;
  localparam logic [5:0] K_ERROR  = 6'd1;
  localparam logic [5:0] K_IDENT  = 6'd2;
  localparam logic [5:0] K_INT    = 6'd3;
  localparam logic [5:0] K_REAL   = 6'd4;
  localparam logic [5:0] K_STRING = 6'd5;
  localparam logic [5:0] K_STAR   = 6'd41;
  localparam logic [5:0] K_COMMA  = 6'd42;
  localparam logic [5:0] K_SEMI   = 6'd43;
  localparam logic [5:0] K_LPAREN = 6'd44;
  localparam logic [5:0] K_RPAREN = 6'd45;
  localparam logic [5:0] K_DOT    = 6'd46;
  localparam logic [5:0] K_PLUS   = 6'd47;
  localparam logic [5:0] K_MINUS  = 6'd48;
  localparam logic [5:0] K_SLASH  = 6'd49;
  localparam logic [5:0] K_EQ     = 6'd50;
  localparam logic [5:0] K_LE     = 6'd51;
  localparam logic [5:0] K_NEQ    = 6'd52;
  localparam logic [5:0] K_LT     = 6'd53;
  localparam logic [5:0] K_GE     = 6'd54;
  localparam logic [5:0] K_GT     = 6'd55;

  localparam logic [62:0] INT_MAX = {63{1'b1}};

  typedef struct packed {
    logic [5:0]  kind;
    logic [15:0] offset;
    logic [15:0] length;
    logic [62:0] value;
    logic        last;
  } sqlts_tok_t;

  typedef struct packed {
    logic [2:0] level;
  } sqlts_qstat_t;

  // words right-justified, zero padded on the left
  localparam logic [8*KW_CHARS-1:0] KW_WORD [KW_COUNT] = '{
    "SELECT", "FROM", "WHERE", "INSERT", "INTO", "VALUES", "CREATE", "TABLE", "DROP",
    "INDEX", "ON", "UPDATE", "SET", "DELETE", "JOIN", "INNER", "ORDER", "BY", "ASC",
    "DESC", "LIMIT", "AND", "OR", "NOT", "NULL", "PRIMARY", "KEY", "AS", "INT",
    "INTEGER", "REAL", "FLOAT", "DOUBLE", "TEXT", "VARCHAR", "CHAR", "STRING",
    "BEGIN", "COMMIT", "ROLLBACK", "TRANSACTION"
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd6, 4'd4, 4'd5, 4'd6, 4'd4, 4'd6, 4'd6, 4'd5, 4'd4, 4'd5, 4'd2, 4'd6, 4'd3,
    4'd6, 4'd4, 4'd5, 4'd5, 4'd2, 4'd3, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd4, 4'd7,
    4'd3, 4'd2, 4'd3, 4'd7, 4'd4, 4'd5, 4'd6, 4'd4, 4'd7, 4'd4, 4'd6, 4'd5, 4'd6,
    4'd8, 4'd11
  };
  localparam logic [5:0] KW_KIND [KW_COUNT] = '{
    6'd6, 6'd7, 6'd8, 6'd9, 6'd10, 6'd11, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
    6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd34, 6'd35, 6'd35, 6'd35, 6'd36,
    6'd36, 6'd36, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40
  };

  // name holds the first chars, char 0 in the low byte
  function automatic logic [5:0] kw_lookup(input logic [8*KW_CHARS-1:0] name,
                                           input logic [KW_CNT_W-1:0] cnt);
    logic [8*KW_CHARS-1:0] packed_name;
    logic [5:0] kind;
    packed_name = '0;
    kind = K_IDENT;
    for (int i = 0; i < KW_CHARS; i++) begin
      if (KW_CNT_W'(i) < cnt) packed_name = {packed_name[8*KW_CHARS-9:0], name[8*i +: 8]};
    end
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cnt == KW_CNT_W'(KW_LEN[k]) && packed_name == KW_WORD[k]) kind = KW_KIND[k];
    end
    return kind;
  endfunction

endpackage

/* sv/sqlts_core.sv */
// sqlts_core: scanner state and per-item token logic, up to two result items per input item
// depends on sqlts_pkg
module sqlts_core #(
  parameter int MAX_TEXT_BYTES  = sqlts_pkg::MAX_TEXT_BYTES_DEF,
  parameter int LONGEST_KEYWORD = sqlts_pkg::LONGEST_KEYWORD_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_go,
  input  logic                  item_eot,
  input  logic [7:0]            item_byte,
  output sqlts_pkg::sqlts_tok_t res0,
  output sqlts_pkg::sqlts_tok_t res1,
  output logic [1:0]            res_n
);

  localparam int PW = $clog2(MAX_TEXT_BYTES + 1);
  localparam int CW = $clog2(LONGEST_KEYWORD + 2);
  localparam int IW = $clog2(LONGEST_KEYWORD);

  typedef enum logic [3:0] {
    M_IDLE, M_DASH, M_COMMENT, M_IDENT, M_INT, M_REAL, M_STR, M_STRQ, M_LT, M_GT, M_BANG
  } mode_t;

  mode_t        mode_r, mode_nxt;
  logic [PW-1:0] pos_r, pos_nxt, tb_r, tb_nxt;
  logic [CW-1:0] nc_r, nc_nxt;
  logic [62:0]   acc_r, acc_nxt;
  logic [7:0]    name_r [LONGEST_KEYWORD];
  logic          name_we;
  logic [IW-1:0] name_idx;
  logic [7:0]    name_dat;

  sqlts_pkg::sqlts_tok_t res_v [2];
  logic [1:0]  n;
  logic        do_flush, do_start;
  logic        c_alpha, c_digit, c_space, c_word;
  logic [7:0]  c_up;
  logic [66:0] acc_x10;
  logic [62:0] acc_cont;
  logic [8*sqlts_pkg::KW_CHARS-1:0] name_vec;
  logic [5:0]  name_kind;
  logic [15:0] tok_len;
  logic [5:0]  op_kind;

  always_comb begin
    c_alpha = (item_byte >= "a" && item_byte <= "z") || (item_byte >= "A" && item_byte <= "Z");
    c_digit = item_byte >= "0" && item_byte <= "9";
    c_space = item_byte == " " || (item_byte >= 8'd9 && item_byte <= 8'd13);
    c_word  = c_alpha || c_digit || item_byte == "_";
    c_up    = (item_byte >= "a" && item_byte <= "z") ? item_byte - 8'd32 : item_byte;
    // acc*10 + digit, saturating
    acc_x10 = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {63'd0, item_byte[3:0]};
    acc_cont = (acc_x10[66:63] != 4'd0) ? sqlts_pkg::INT_MAX : acc_x10[62:0];
    for (int i = 0; i < sqlts_pkg::KW_CHARS; i++) name_vec[8*i +: 8] = name_r[i];
    name_kind = (nc_r > CW'(LONGEST_KEYWORD)) ? sqlts_pkg::K_IDENT :
                sqlts_pkg::kw_lookup(name_vec, sqlts_pkg::KW_CNT_W'(nc_r));
    tok_len = 16'(pos_r - tb_r);
    case (item_byte)
      "*":     op_kind = sqlts_pkg::K_STAR;
      ",":     op_kind = sqlts_pkg::K_COMMA;
      ";":     op_kind = sqlts_pkg::K_SEMI;
      "(":     op_kind = sqlts_pkg::K_LPAREN;
      ")":     op_kind = sqlts_pkg::K_RPAREN;
      ".":     op_kind = sqlts_pkg::K_DOT;
      "+":     op_kind = sqlts_pkg::K_PLUS;
      "/":     op_kind = sqlts_pkg::K_SLASH;
      "=":     op_kind = sqlts_pkg::K_EQ;
      default: op_kind = sqlts_pkg::K_ERROR;
    endcase
  end

  always_comb begin
    mode_nxt = mode_r;
    pos_nxt  = pos_r;
    tb_nxt   = tb_r;
    nc_nxt   = nc_r;
    acc_nxt  = acc_r;
    name_we  = 1'b0;
    name_idx = '0;
    name_dat = c_up;
    res_v[0] = '0;
    res_v[1] = '0;
    n        = 2'd0;
    do_flush = 1'b0;
    do_start = 1'b0;
    if (item_go) begin
      if (item_eot) begin
        do_flush = 1'b1;
      end else if (pos_r < PW'(MAX_TEXT_BYTES)) begin
        pos_nxt = pos_r + 1'b1;
        case (mode_r)
          M_COMMENT: begin
            if (item_byte == 8'h0a) mode_nxt = M_IDLE;
          end
          M_DASH: begin
            if (item_byte == "-") mode_nxt = M_COMMENT;
            else do_start = 1'b1;
          end
          M_IDENT: begin
            if (c_word) begin
              if (nc_r < CW'(LONGEST_KEYWORD)) begin
                name_we  = 1'b1;
                name_idx = IW'(nc_r);
              end
              if (nc_r <= CW'(LONGEST_KEYWORD)) nc_nxt = nc_r + 1'b1;
            end else do_start = 1'b1;
          end
          M_INT: begin
            if (c_digit) acc_nxt = acc_cont;
            else if (item_byte == ".") mode_nxt = M_REAL;
            else do_start = 1'b1;
          end
          M_REAL: begin
            if (!c_digit) do_start = 1'b1;
          end
          M_STR: begin
            if (item_byte == "'") mode_nxt = M_STRQ;
          end
          M_STRQ: begin
            if (item_byte == "'") mode_nxt = M_STR;
            else do_start = 1'b1;
          end
          M_LT: begin
            if (item_byte == "=" || item_byte == ">") begin
              res_v[0] = '{(item_byte == "=") ? sqlts_pkg::K_LE : sqlts_pkg::K_NEQ,
                           16'(tb_r), 16'd2, 63'd0, 1'b0};
              n = 2'd1;
              mode_nxt = M_IDLE;
            end else do_start = 1'b1;
          end
          M_GT, M_BANG: begin
            if (item_byte == "=") begin
              res_v[0] = '{(mode_r == M_GT) ? sqlts_pkg::K_GE : sqlts_pkg::K_NEQ,
                           16'(tb_r), 16'd2, 63'd0, 1'b0};
              n = 2'd1;
              mode_nxt = M_IDLE;
            end else do_start = 1'b1;
          end
          default: do_start = 1'b1;
        endcase
        do_flush = do_start;
      end
    end

    if (do_flush) begin
      case (mode_r)
        M_DASH:  begin res_v[0] = '{sqlts_pkg::K_MINUS, 16'(tb_r), 16'd1, 63'd0, 1'b0}; n = 2'd1; end
        M_IDENT: begin res_v[0] = '{name_kind, 16'(tb_r), tok_len, 63'd0, 1'b0}; n = 2'd1; end
        M_INT:   begin res_v[0] = '{sqlts_pkg::K_INT, 16'(tb_r), tok_len, acc_r, 1'b0}; n = 2'd1; end
        M_REAL:  begin res_v[0] = '{sqlts_pkg::K_REAL, 16'(tb_r), tok_len, 63'd0, 1'b0}; n = 2'd1; end
        M_STR:   begin res_v[0] = '{sqlts_pkg::K_ERROR, 16'(tb_r), tok_len, 63'd0, 1'b0}; n = 2'd1; end
        M_STRQ:  begin res_v[0] = '{sqlts_pkg::K_STRING, 16'(tb_r), tok_len, 63'd0, 1'b0}; n = 2'd1; end
        M_LT:    begin res_v[0] = '{sqlts_pkg::K_LT, 16'(tb_r), 16'd1, 63'd0, 1'b0}; n = 2'd1; end
        M_GT:    begin res_v[0] = '{sqlts_pkg::K_GT, 16'(tb_r), 16'd1, 63'd0, 1'b0}; n = 2'd1; end
        M_BANG:  begin res_v[0] = '{sqlts_pkg::K_ERROR, 16'(tb_r), 16'd1, 63'd0, 1'b0}; n = 2'd1; end
        default: ;
      endcase
      mode_nxt = M_IDLE;
    end

    if (do_start && !c_space) begin
      tb_nxt = pos_r;
      if (c_alpha || item_byte == "_") begin
        mode_nxt = M_IDENT;
        nc_nxt   = CW'(1);
        name_we  = 1'b1;
        name_idx = '0;
      end else if (c_digit) begin
        mode_nxt = M_INT;
        acc_nxt  = {59'd0, item_byte[3:0]};
      end else begin
        case (item_byte)
          "-":     mode_nxt = M_DASH;
          "'":     mode_nxt = M_STR;
          "<":     mode_nxt = M_LT;
          ">":     mode_nxt = M_GT;
          "!":     mode_nxt = M_BANG;
          default: begin
            res_v[n[0]] = '{op_kind, 16'(pos_r), 16'd1, 63'd0, 1'b0};
            n = n + 2'd1;
          end
        endcase
      end
    end

    // end of text: emit eof and return to the reset state
    if (item_go && item_eot) begin
      res_v[n[0]] = '{sqlts_pkg::K_EOF, 16'(pos_r), 16'd0, 63'd0, 1'b0};
      n        = n + 2'd1;
      mode_nxt = M_IDLE;
      pos_nxt  = '0;
      tb_nxt   = '0;
      nc_nxt   = '0;
      acc_nxt  = '0;
    end

    if (n == 2'd2) res_v[1].last = 1'b1;
    else res_v[0].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      pos_r  <= '0;
      tb_r   <= '0;
      nc_r   <= '0;
      acc_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      pos_r  <= pos_nxt;
      tb_r   <= tb_nxt;
      nc_r   <= nc_nxt;
      acc_r  <= acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (name_we) name_r[name_idx] <= name_dat;
  end

  assign res0  = res_v[0];
  assign res1  = res_v[1];
  assign res_n = n;

endmodule

/* sv/sqlts_outq.sv */
// sqlts_outq: four-entry result queue, up to two writes and one read per cycle
// depends on sqlts_pkg
module sqlts_outq (
  input  logic                    clk,
  input  logic                    rst_n,
  input  sqlts_pkg::sqlts_tok_t   wr0,
  input  sqlts_pkg::sqlts_tok_t   wr1,
  input  logic [1:0]              wr_n,
  output logic                    room,
  output logic                    rd_valid,
  input  logic                    rd_ready,
  output sqlts_pkg::sqlts_tok_t   rd_data,
  output sqlts_pkg::sqlts_qstat_t stat
);

  sqlts_pkg::sqlts_tok_t mem [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] level_r;
  logic       pop;

  assign pop      = rd_valid && rd_ready;
  assign rd_valid = level_r != 3'd0;
  assign rd_data  = mem[rp_r];
  assign room     = level_r <= 3'd2;
  assign stat.level = level_r;

  always_ff @(posedge clk) begin
    if (wr_n != 2'd0) mem[wp_r] <= wr0;
    if (wr_n == 2'd2) mem[wp_r + 2'd1] <= wr1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      rp_r    <= '0;
      level_r <= '0;
    end else begin
      wp_r    <= wp_r + wr_n;
      rp_r    <= rp_r + {1'b0, pop};
      level_r <= level_r + {1'b0, wr_n} - {2'b00, pop};
    end
  end

endmodule

/* sv/sql_token_scanner.sv */
// sql_token_scanner: streaming sql lexer, one text byte or end of text per input item
// depends on sqlts_pkg, sqlts_core, sqlts_outq
//
//  channel  | ports                          | item
//  in       | in_tvalid/tready/tdata/tuser   | text byte, or end of text
//  out      | out_tvalid/tready/tdata/tlast  | token, tlast on last token of an item
//
// one input item per cycle; each item yields zero, one or two tokens in the same cycle,
// written into a four-entry queue that drains one token per cycle if out_tready is high
// in_tready drops while the queue holds more than two tokens
// synchronous active-low reset clears scanner state and queue; no clearing pass
module sql_token_scanner #(
  parameter int MAX_TEXT_BYTES  = sqlts_pkg::MAX_TEXT_BYTES_DEF,
  parameter int LONGEST_KEYWORD = sqlts_pkg::LONGEST_KEYWORD_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // char_byte
  input  logic [0:0]   in_tuser,   // req_type
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // token_kind, token_offset, token_length, integer_value
  output logic         out_tlast
);

  sqlts_pkg::sqlts_tok_t   res0, res1, head;
  sqlts_pkg::sqlts_qstat_t qstat;
  logic [1:0] res_n;
  logic       go;

  assign go = in_tvalid && in_tready;

  sqlts_core #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES),
    .LONGEST_KEYWORD(LONGEST_KEYWORD)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_go  (go),
    .item_eot (in_tuser[0]),
    .item_byte(in_tdata),
    .res0     (res0),
    .res1     (res1),
    .res_n    (res_n)
  );

  sqlts_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr0     (res0),
    .wr1     (res1),
    .wr_n    (res_n),
    .room    (in_tready),
    .rd_valid(out_tvalid),
    .rd_ready(out_tready),
    .rd_data (head),
    .stat    (qstat)
  );

  assign out_tdata = {3'b000, head.value, head.length, head.offset, head.kind};
  assign out_tlast = head.last;

  a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.level <= 3'd4) else $error("result queue overfilled");

  a_eot_queued: assert property (@(posedge clk) disable iff (!rst_n)
    go && in_tuser[0] |=> out_tvalid) else $error("end of text left no token");

  a_byte_results: assert property (@(posedge clk) disable iff (!rst_n)
    go |-> res_n != 2'd3) else $error("more than two tokens for one item");

endmodule
